// File: hw/rtl/dirat_pkg.sv
// shared types and field widths for the dual-issue rename alias table
package dirat_pkg;

    localparam int REG_BITS   = 5;   // architectural register number field
    localparam int PHYS_BITS  = 6;   // physical tag field
    localparam int SLOTS      = 2;
    localparam int SRCS       = 4;   // rs1 slot0, rs1 slot1, rs2 slot0, rs2 slot1
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    // input transfer, last field (flush) in the lowest bits
    typedef struct packed {
        logic                          pad;
        logic [SLOTS-1:0]              copy_dir;
        logic [SLOTS-1:0]              copy_en;
        logic [SLOTS*PHYS_BITS-1:0]    retire_phys;
        logic [SLOTS*REG_BITS-1:0]     retire_dest;
        logic [SLOTS-1:0]              retire_en;
        logic [SLOTS*PHYS_BITS-1:0]    alloc_phys;
        logic [SLOTS*REG_BITS-1:0]     alloc_dest;
        logic [SLOTS-1:0]              alloc_valid;
        logic [SRCS*REG_BITS-1:0]      src_addr;
        logic [SRCS-1:0]               src_use;
        logic [SLOTS-1:0]              spec_en;
        logic                          flush;
    } in_item_t;

    // result transfer, last field (path_used) in the lowest bits
    typedef struct packed {
        logic [5:0]                    pad;
        logic [PHYS_BITS-1:0]          phys_rs2_slot1;
        logic [PHYS_BITS-1:0]          phys_rs2_slot0;
        logic [PHYS_BITS-1:0]          phys_rs1_slot1;
        logic [PHYS_BITS-1:0]          phys_rs1_slot0;
        logic [SLOTS-1:0]              path_used;
    } out_item_t;

endpackage

// File: hw/rtl/dirat_maps.sv
// speculative and retirement rename maps with lookup, bypass and update
module dirat_maps #(
    parameter int ARCH_REGS = 32,
    parameter int TAG_BITS  = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                upd_en,
    input  dirat_pkg::in_item_t item,
    output dirat_pkg::out_item_t rslt
);
    import dirat_pkg::*;

    localparam int IDX_W = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;

    logic [TAG_BITS-1:0] map_a_reg   [ARCH_REGS];
    logic [TAG_BITS-1:0] map_b_reg   [ARCH_REGS];
    logic [TAG_BITS-1:0] retire_reg  [ARCH_REGS];
    logic [TAG_BITS-1:0] map_a_next  [ARCH_REGS];
    logic [TAG_BITS-1:0] map_b_next  [ARCH_REGS];
    logic [TAG_BITS-1:0] retire_next [ARCH_REGS];

    logic [TAG_BITS-1:0] src_tag [SRCS];
    logic                copy_dir_sel;

    function automatic logic writable(input logic [REG_BITS-1:0] r);
        return (r != '0) && (int'(r) < ARCH_REGS);
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [REG_BITS-1:0] r);
        return IDX_W'(r);
    endfunction

    // source lookups against the maps as they stand before this item, with slot 1 bypass from slot 0's alloc
    always_comb begin
        logic [REG_BITS-1:0] d0;
        logic [TAG_BITS-1:0] tag0;
        logic                byp;
        logic [REG_BITS-1:0] r;
        logic                sel_a;
        d0   = item.alloc_dest[0 +: REG_BITS];
        tag0 = TAG_BITS'(item.alloc_phys[0 +: PHYS_BITS]);
        byp  = item.alloc_valid[0] && writable(d0) && (item.spec_en[0] == item.spec_en[1]);
        for (int k = 0; k < SRCS; k++) begin
            r     = item.src_addr[k*REG_BITS +: REG_BITS];
            sel_a = item.spec_en[k % 2];
            if (!item.src_use[k] || !writable(r)) begin
                src_tag[k] = '0;
            end else if ((k % 2 == 1) && byp && (r == d0)) begin
                src_tag[k] = tag0;
            end else begin
                src_tag[k] = sel_a ? map_a_reg[to_idx(r)] : map_b_reg[to_idx(r)];
            end
        end
    end

    always_comb begin
        rslt                = '0;
        rslt.path_used      = item.spec_en;
        rslt.phys_rs1_slot0 = PHYS_BITS'(src_tag[0]);
        rslt.phys_rs1_slot1 = PHYS_BITS'(src_tag[1]);
        rslt.phys_rs2_slot0 = PHYS_BITS'(src_tag[2]);
        rslt.phys_rs2_slot1 = PHYS_BITS'(src_tag[3]);
    end

    // slot 1 copy request wins
    assign copy_dir_sel = item.copy_en[1] ? item.copy_dir[1] : item.copy_dir[0];

    // update order: copy, retire slot0/1, alloc slot0/1, later writes win; a flush only sets a/b to retire
    always_comb begin
        logic [REG_BITS-1:0] rd;
        map_a_next  = map_a_reg;
        map_b_next  = map_b_reg;
        retire_next = retire_reg;
        rd          = '0;
        if (upd_en) begin
            if (item.flush) begin
                map_a_next = retire_reg;
                map_b_next = retire_reg;
            end else begin
                if (item.copy_en != '0) begin
                    if (copy_dir_sel) begin
                        map_b_next = map_a_reg;
                    end else begin
                        map_a_next = map_b_reg;
                    end
                end
                for (int k = 0; k < SLOTS; k++) begin
                    rd = item.retire_dest[k*REG_BITS +: REG_BITS];
                    if (item.retire_en[k] && writable(rd)) begin
                        retire_next[to_idx(rd)] =
                            TAG_BITS'(item.retire_phys[k*PHYS_BITS +: PHYS_BITS]);
                    end
                end
                for (int k = 0; k < SLOTS; k++) begin
                    rd = item.alloc_dest[k*REG_BITS +: REG_BITS];
                    if (item.alloc_valid[k] && writable(rd)) begin
                        if (item.spec_en[k]) begin
                            map_a_next[to_idx(rd)] =
                                TAG_BITS'(item.alloc_phys[k*PHYS_BITS +: PHYS_BITS]);
                        end else begin
                            map_b_next[to_idx(rd)] =
                                TAG_BITS'(item.alloc_phys[k*PHYS_BITS +: PHYS_BITS]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ARCH_REGS; i++) begin
                map_a_reg[i]  <= TAG_BITS'(i);
                map_b_reg[i]  <= TAG_BITS'(i);
                retire_reg[i] <= TAG_BITS'(i);
            end
        end else begin
            map_a_reg  <= map_a_next;
            map_b_reg  <= map_b_next;
            retire_reg <= retire_next;
        end
    end

endmodule

// File: hw/rtl/dual_issue_rename_alias_table_unit.sv
// top level of the dual-issue rename alias table
// a bundle passes through the input register, then the result register
// one bundle per cycle while m_tready holds; the maps are read and updated in one pass
// the bundle in the input register sees every update of the bundle before it
// reset (aresetn low, synchronous) empties both stages and sets map entry i to i
// no clearing pass: all maps are flip-flops reloaded in the reset cycle
module dual_issue_rename_alias_table_unit #(
    parameter int ARCH_REGS = 32,
    parameter int TAG_BITS  = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // flush, spec_en, src_use, src_addr, alloc_valid, alloc_dest, alloc_phys,
    // retire_en, retire_dest, retire_phys, copy_en, copy_dir, zero pad
    input  logic [dirat_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // path_used, phys_rs1_slot0, phys_rs1_slot1, phys_rs2_slot0,
    // phys_rs2_slot1, zero pad
    output logic [dirat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dirat_pkg::*;

    // input register: holds one bundle until the result register is free
    in_item_t  in_reg;
    logic      in_valid_reg;
    // result register
    out_item_t out_reg;
    logic      out_valid_reg;

    out_item_t rslt;
    logic      advance;

    // bundle moves to the result register and commits its map updates
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // a new transfer is taken when the input register is empty or the held bundle leaves in the same cycle
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_item_t'(s_tdata);
        end
    end

    // lookup, slot 1 bypass and map update for the held bundle
    dirat_maps #(
        .ARCH_REGS (ARCH_REGS),
        .TAG_BITS  (TAG_BITS)
    ) u_maps (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (advance),
        .item    (in_reg),
        .rslt    (rslt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= rslt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

// File: hw/rtl/dirat_checker.sv
// port-level checks for the dual-issue rename alias table
module dirat_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dirat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dirat_pkg::*;

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only stalls when a result is stuck on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // padding above the last tag is always zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:26] == '0)
        else $error("nonzero padding in result");

endmodule

bind dual_issue_rename_alias_table_unit dirat_checker u_dirat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
